### design/trssm_pkg.sv
// ----------------------------------------------------------------------------
// trssm_pkg
// Types and constants of the two-real spectrum split and magnitude unit.
// ----------------------------------------------------------------------------
package trssm_pkg;

  localparam int unsigned FFT_POINTS_DEF = 512;
  localparam int unsigned BIN_W          = 9;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned AMP_W          = 32;
  localparam int unsigned ROOT_STEPS     = AMP_W;
  localparam int unsigned RADICAND_W     = 2 * AMP_W;
  localparam int unsigned REM_W          = AMP_W + 2;
  localparam int unsigned LANES          = 2;
  localparam int unsigned COMPS          = 4;
  localparam logic [AMP_W-1:0] AMP_MAX   = 32'd3037000499;

  typedef struct packed {
    logic [BIN_W-1:0]           bin_index;
    logic signed [SAMPLE_W-1:0] fwd_re;
    logic signed [SAMPLE_W-1:0] fwd_im;
    logic signed [SAMPLE_W-1:0] mirror_re;
    logic signed [SAMPLE_W-1:0] mirror_im;
  } trssm_in_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp_a;
    logic [AMP_W-1:0] amp_b;
  } trssm_out_t;

endpackage

### design/two_real_spectrum_split_magnitude_unit.sv
// ----------------------------------------------------------------------------
// two_real_spectrum_split_magnitude_unit
// Splits a packed two-channel FFT bin pair and gives both floor magnitudes.
// ----------------------------------------------------------------------------
// One item enters per clock while the output is not stalled: one stage
// forms the halved channel terms, one takes absolute values, one squares, one
// adds the squares, and 32 stages each settle one bit of the integer square
// root for both channels; the last root stage is the output register. A stall
// on the output freezes the whole pipeline, so nothing is lost or repeated.
// Bin 0 and bins at or above FFT_POINTS/2 give zero amplitudes.
module two_real_spectrum_split_magnitude_unit #(
  parameter int unsigned FFT_POINTS = trssm_pkg::FFT_POINTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  trssm_pkg::trssm_in_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output trssm_pkg::trssm_out_t out_item_o
);

  localparam int unsigned AW = trssm_pkg::AMP_W;
  localparam int unsigned SW = trssm_pkg::SAMPLE_W;
  localparam int unsigned VW = trssm_pkg::RADICAND_W;
  localparam int unsigned RW = trssm_pkg::REM_W;
  localparam int unsigned NS = trssm_pkg::ROOT_STEPS;
  localparam int unsigned NL = trssm_pkg::LANES;
  localparam int unsigned NC = trssm_pkg::COMPS;
  localparam int unsigned BW = trssm_pkg::BIN_W;
  localparam logic [31:0] HalfPts = 32'(FFT_POINTS / 2);

  function automatic logic signed [SW-1:0] halve(input logic signed [SW+1:0] s);
    logic signed [SW+1:0] t;
    t = s + {{(SW+1){1'b0}}, s[SW+1]};
    return t[SW:1];
  endfunction

  logic en;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: halved channel terms
  logic                 s1_vld_q;
  logic signed [SW-1:0] half_q [NC];
  logic signed [SW-1:0] half_d [NC];
  logic                 zero_bin;
  logic signed [SW+1:0] xr, xi, yr, yi;

  always_comb begin
    xr = (SW+2)'(in_item_i.fwd_re);
    xi = (SW+2)'(in_item_i.fwd_im);
    yr = (SW+2)'(in_item_i.mirror_re);
    yi = (SW+2)'(in_item_i.mirror_im);
    zero_bin = (in_item_i.bin_index == '0) ||
               ({{(32-BW){1'b0}}, in_item_i.bin_index} >= HalfPts);
    half_d[0] = halve(xr + yr);
    half_d[1] = halve(xi - yi);
    half_d[2] = halve(xi + yi);
    half_d[3] = halve(xr - yr);
    if (zero_bin) begin
      for (int c = 0; c < NC; c++) half_d[c] = '0;
    end
  end

  // stage 2: magnitudes, stage 3: squares, stage 4: sums
  logic          s2_vld_q, s3_vld_q;
  logic [AW-1:0] mag_q [NC];
  logic [VW-1:0] sq_q  [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        half_q[c] <= half_d[c];
        mag_q[c]  <= half_q[c][SW-1] ? AW'(-half_q[c]) : AW'(half_q[c]);
        sq_q[c]   <= VW'(mag_q[c]) * VW'(mag_q[c]);
      end
    end
  end

  // square root pipeline, index 0 holds the sums of squares
  logic          vld_q  [NS+1];
  logic [VW-1:0] rad_q  [NL][NS+1];
  logic [RW-1:0] rem_q  [NL][NS+1];
  logic [AW-1:0] root_q [NL][NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s3_vld_q;
      for (int s = 0; s < NS; s++) vld_q[s+1] <= vld_q[s];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[l][0]  <= sq_q[2*l] + sq_q[2*l+1];
        rem_q[l][0]  <= '0;
        root_q[l][0] <= '0;
      end
    end

    for (genvar s = 0; s < NS; s++) begin : g_step
      logic [RW+1:0] acc;
      logic [RW+1:0] trial;
      logic          take;

      always_comb begin
        acc   = {rem_q[l][s], rad_q[l][s][VW-1 -: 2]};
        trial = (RW+2)'({root_q[l][s], 2'b01});
        take  = acc >= trial;
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          rad_q[l][s+1]  <= {rad_q[l][s][VW-3:0], 2'b00};
          rem_q[l][s+1]  <= take ? RW'(acc - trial) : RW'(acc);
          root_q[l][s+1] <= {root_q[l][s][AW-2:0], take};
        end
      end
    end
  end

  assign out_valid_o      = vld_q[NS];
  assign out_item_o.amp_a = root_q[0][NS];
  assign out_item_o.amp_b = root_q[1][NS];

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_amp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.amp_a <= trssm_pkg::AMP_MAX) &&
                    (out_item_o.amp_b <= trssm_pkg::AMP_MAX))
    else $error("amplitude out of range");

  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && s3_vld_q |=> vld_q[0])
    else $error("item dropped in pipeline");

endmodule
